>>> rtl/msbt_pkg.sv
package msbt_pkg;

  localparam int DEF_CAPACITY      = 256;
  localparam int DEF_ELEMENT_WIDTH = 32;
  localparam int FIELD_W           = 9;
  localparam int VALUE_W           = 32;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_ERASE_ONE = 2'd1,
    REQ_ERASE_ALL = 2'd2,
    REQ_COUNT     = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_MOVE  = 2'd2
  } state_t;

  typedef struct packed {
    req_kind_t            req_type;
    logic [VALUE_W-1:0]   item_value;
  } in_t;

  typedef struct packed {
    status_t              status_code;
    logic [FIELD_W-1:0]   tally;
    logic [FIELD_W-1:0]   occupancy;
  } out_t;

endpackage

>>> rtl/msbt_ram.sv
module msbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/multiset_bag_table.sv
// Channel   Ports                   Transaction
// input     start, busy, in_item    start high while busy is low
// result    out_valid, out_result   out_valid high for one cycle
//
// An insert is written when it is taken; its result appears on the next cycle.
// Erase and count requests scan the store through one read port of the
// element memory, checking each held element in turn; an erase moves the
// last element into each freed slot, and an erase-all checks that slot again.
// Reset empties the store at once; no clearing pass is needed.
// Results are registered and cannot be stalled; a new request may be taken
// in the cycle its predecessor's result is shown.
module multiset_bag_table
  import msbt_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_result
);

  state_t                   state_r, state_nxt;
  req_kind_t                kind_r, kind_nxt;
  logic [ELEMENT_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            tally_r, tally_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_result_r, out_result_nxt;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data, rd_data;

  logic [63:0]              wide_value;
  logic [ELEMENT_WIDTH-1:0] val_in;
  logic [CW-1:0]            idx_inc, cnt_dec, tally_inc, tally_chk;
  logic                     hit, done;
  status_t                  fin_status;
  logic [CW-1:0]            fin_tally;

  assign wide_value = 64'(in_item.item_value);
  assign val_in     = wide_value[ELEMENT_WIDTH-1:0];
  assign idx_inc    = idx_r + CW'(1);
  assign cnt_dec    = cnt_r - CW'(1);
  assign tally_inc  = tally_r + CW'(1);
  assign hit        = (rd_data == val_r);
  assign tally_chk  = hit ? tally_inc : tally_r;

  msbt_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    tally_r      <= tally_nxt;
    out_result_r <= out_result_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    tally_nxt  = tally_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = idx_r[AW-1:0];
    done       = 1'b0;
    fin_status = STAT_DONE;
    fin_tally  = tally_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt = in_item.req_type;
          val_nxt  = val_in;
          if (in_item.req_type == REQ_INSERT) begin
            done = 1'b1;
            if (cnt_r == CW'(CAPACITY)) begin
              fin_status = STAT_FULL;
              fin_tally  = '0;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = cnt_r[AW-1:0];
              wr_data   = val_in;
              cnt_nxt   = cnt_r + CW'(1);
              fin_tally = CW'(1);
            end
          end else begin
            tally_nxt = '0;
            idx_nxt   = '0;
            if (cnt_r == '0) begin
              done       = 1'b1;
              fin_status = STAT_NOMATCH;
              fin_tally  = '0;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (hit && kind_r != REQ_COUNT) begin
          cnt_nxt   = cnt_dec;
          tally_nxt = tally_inc;
          rd_en     = 1'b1;
          rd_addr   = cnt_dec[AW-1:0];
          state_nxt = ST_MOVE;
        end else begin
          tally_nxt = tally_chk;
          idx_nxt   = idx_inc;
          if (idx_inc < cnt_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end else begin
            done       = 1'b1;
            fin_tally  = tally_chk;
            fin_status = (tally_chk == '0) ? STAT_NOMATCH : STAT_DONE;
          end
        end
      end
      ST_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data;
        if (kind_r == REQ_ERASE_ONE || idx_r >= cnt_r) begin
          done = 1'b1;
        end else if (hit) begin
          cnt_nxt   = cnt_dec;
          tally_nxt = tally_inc;
          rd_en     = 1'b1;
          rd_addr   = cnt_dec[AW-1:0];
        end else begin
          idx_nxt = idx_inc;
          if (idx_inc < cnt_r) begin
            rd_en     = 1'b1;
            rd_addr   = idx_inc[AW-1:0];
            state_nxt = ST_CHECK;
          end else begin
            done = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = ST_IDLE;
    end

    out_valid_nxt              = done;
    out_result_nxt.status_code = fin_status;
    out_result_nxt.tally       = FIELD_W'(fin_tally);
    out_result_nxt.occupancy   = FIELD_W'(cnt_nxt);
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_insert_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.req_type == REQ_INSERT |=> out_valid && !busy)
    else $error("insert did not finish in one cycle");

  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.occupancy == FIELD_W'(cnt_r))
    else $error("reported occupancy differs from count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> idx_r < cnt_r)
    else $error("scan index beyond held elements");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.status_code == STAT_NOMATCH |-> out_result.tally == '0)
    else $error("no-match result with nonzero tally");

  a_busy_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a request is still running");

endmodule

>>> dv/multiset_bag_table_test.sv
`timescale 1ns / 1ps

module multiset_bag_table_test;
  import msbt_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int ELEM_W = DEF_ELEMENT_WIDTH;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - ELEM_W);
  localparam int RANDOM_ITEMS = 1930;
  localparam int CALM_TAIL = 150;
  localparam int SETTLE_CYCLES = 2 * CAP + 40;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int PROBE_ROWS = 22;

  typedef struct packed {
    req_kind_t kind;
    logic [VALUE_W-1:0] value;
    logic typed;
    status_t status_code;
    logic [FIELD_W-1:0] tally;
    logic [FIELD_W-1:0] occupancy;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_result;

  logic [VALUE_W-1:0] bag_store [CAP];
  int unsigned bag_count = 0;
  out_t pending_results [$];
  int unsigned mismatches = 0;
  longint cycle_count = 0;

  probe_row_t probe_rows [PROBE_ROWS] = '{
    {REQ_COUNT,     32'h0000_0000, 1'b1, STAT_NOMATCH, 9'd0, 9'd0},
    {REQ_ERASE_ONE, 32'h0000_0000, 1'b1, STAT_NOMATCH, 9'd0, 9'd0},
    {REQ_ERASE_ALL, 32'hFFFF_FFFF, 1'b1, STAT_NOMATCH, 9'd0, 9'd0},
    {REQ_INSERT,    32'h0000_0000, 1'b1, STAT_DONE,    9'd1, 9'd1},
    {REQ_INSERT,    32'hFFFF_FFFF, 1'b1, STAT_DONE,    9'd1, 9'd2},
    {REQ_INSERT,    32'hFFFF_FFFF, 1'b1, STAT_DONE,    9'd1, 9'd3},
    {REQ_INSERT,    32'h0000_0005, 1'b1, STAT_DONE,    9'd1, 9'd4},
    {REQ_COUNT,     32'hFFFF_FFFF, 1'b1, STAT_DONE,    9'd2, 9'd4},
    {REQ_INSERT,    32'hAAAA_AAAA, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_INSERT,    32'h5555_5555, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_ERASE_ONE, 32'hFFFF_FFFF, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_INSERT,    32'h0000_0007, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_INSERT,    32'h0000_0007, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_INSERT,    32'h0000_0007, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_ERASE_ALL, 32'h0000_0007, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_COUNT,     32'h0000_0007, 1'b1, STAT_NOMATCH, 9'd0, 9'd5},
    {REQ_ERASE_ONE, 32'h1234_5678, 1'b1, STAT_NOMATCH, 9'd0, 9'd5},
    {REQ_ERASE_ALL, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_ERASE_ALL, 32'hFFFF_FFFF, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_COUNT,     32'h5555_5555, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_ERASE_ONE, 32'hAAAA_AAAA, 1'b0, STAT_DONE,    9'd0, 9'd0},
    {REQ_ERASE_ALL, 32'h0000_0005, 1'b0, STAT_DONE,    9'd0, 9'd0}
  };

  multiset_bag_table #(
    .CAPACITY(CAP),
    .ELEMENT_WIDTH(ELEM_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_result(out_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Applies one request to the local copy of the bag and returns its result.
  function automatic out_t bag_apply(in_t req);
    out_t r;
    logic [VALUE_W-1:0] v;
    int unsigned idx;
    int unsigned hits;
    bit stop;
    v = req.item_value & VALUE_MASK;
    hits = 0;
    idx = 0;
    stop = 1'b0;
    r.status_code = STAT_DONE;
    case (req.req_type)
      REQ_INSERT: begin
        if (bag_count >= CAP) begin
          r.status_code = STAT_FULL;
        end else begin
          bag_store[bag_count] = v;
          bag_count++;
          hits = 1;
        end
      end
      REQ_COUNT: begin
        for (idx = 0; idx < bag_count; idx++) begin
          if (bag_store[idx] == v) hits++;
        end
      end
      default: begin
        // The last element fills the freed slot, and that slot is checked again.
        while (idx < bag_count && !stop) begin
          if (bag_store[idx] == v) begin
            bag_count--;
            bag_store[idx] = bag_store[bag_count];
            hits++;
            if (req.req_type == REQ_ERASE_ONE) stop = 1'b1;
          end else begin
            idx++;
          end
        end
      end
    endcase
    if (req.req_type != REQ_INSERT && hits == 0) r.status_code = STAT_NOMATCH;
    r.tally = hits[FIELD_W-1:0];
    r.occupancy = bag_count[FIELD_W-1:0];
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pool_value(int unsigned pick);
    case (pick)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'hAAAA_AAAA;
      3: return 32'h5555_5555;
      4: return 32'h8000_0001;
      5: return 32'h0000_0001;
      6: return 32'h7FFF_FFFE;
      default: return 32'hC3A5_5A3C;
    endcase
  endfunction

  // Growing phases mostly insert; shrinking phases mostly erase.
  function automatic in_t random_request(bit growing);
    in_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (growing) begin
      r.req_type = (roll < 80) ? REQ_INSERT : req_kind_t'($urandom_range(1, 3));
    end else begin
      r.req_type = (roll < 20) ? REQ_INSERT :
                   (roll < 55) ? REQ_ERASE_ONE :
                   (roll < 80) ? REQ_ERASE_ALL : REQ_COUNT;
    end
    r.item_value = ($urandom_range(0, 4) == 0) ? $urandom : pool_value($urandom_range(0, 7));
    return r;
  endfunction

  task automatic issue(input in_t req, input logic typed, input out_t typed_result);
    out_t predicted;
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = bag_apply(req);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    in_item <= in_t'({$urandom, $urandom});
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_t exp_result;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: status_code %0d tally %0d occupancy %0d",
               out_result.status_code, out_result.tally, out_result.occupancy);
        mismatches++;
      end else begin
        exp_result = pending_results.pop_front();
        if (out_result.status_code !== exp_result.status_code) begin
          $error("status_code expected %0d, got %0d",
                 exp_result.status_code, out_result.status_code);
          mismatches++;
        end
        if (out_result.tally !== exp_result.tally) begin
          $error("tally expected %0d, got %0d", exp_result.tally, out_result.tally);
          mismatches++;
        end
        if (out_result.occupancy !== exp_result.occupancy) begin
          $error("occupancy expected %0d, got %0d",
                 exp_result.occupancy, out_result.occupancy);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    in_t req;
    out_t typed_result;
    int unsigned n;
    int unsigned quiet;
    bit growing;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < PROBE_ROWS; n++) begin
      req.req_type = probe_rows[n].kind;
      req.item_value = probe_rows[n].value;
      typed_result.status_code = probe_rows[n].status_code;
      typed_result.tally = probe_rows[n].tally;
      typed_result.occupancy = probe_rows[n].occupancy;
      if (n % 5 == 3) hold_off($urandom_range(1, 17));
      issue(req, probe_rows[n].typed, typed_result);
    end
    drain_wait();

    growing = 1'b1;
    quiet = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_wait();
      if (quiet > 0) begin
        quiet--;
      end else if ($urandom_range(0, 19) == 0) begin
        quiet = $urandom_range(20, 80);
      end
      if (quiet == 0 && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 4) == 0) begin
        hold_off($urandom_range(1, 17));
      end
      if (growing && bag_count == CAP && $urandom_range(0, 3) == 0) begin
        growing = 1'b0;
      end else if (!growing && bag_count <= $urandom_range(0, 6)) begin
        growing = 1'b1;
      end
      issue(random_request(growing), 1'b0, '0);
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/msbt_pkg.sv
rtl/msbt_ram.sv
rtl/multiset_bag_table.sv
dv/multiset_bag_table_test.sv
